/* hdl/lpsc_pkg.sv */
// Shared types, status codes and register indexes of the laser power step calibrator.
package lpsc_pkg;

   // Status codes reported per beat and kept per channel
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_ADJ       = 3'd1;
   localparam logic [2:0] ST_DONE      = 3'd2;
   localparam logic [2:0] ST_SAT       = 3'd3;
   localparam logic [2:0] ST_LASER_OFF = 3'd4;
   localparam logic [2:0] ST_PD_LOW    = 3'd5;
   localparam logic [2:0] ST_NO_RESP   = 3'd6;

   // Item kinds
   localparam logic KIND_STEP  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Register indexes
   localparam logic [2:0] REG_TARGET_CH0 = 3'd0;
   localparam logic [2:0] REG_TARGET_CH1 = 3'd1;
   localparam logic [2:0] REG_TARGET_CH2 = 3'd2;
   localparam logic [2:0] REG_TOL_SMALL  = 3'd3;
   localparam logic [2:0] REG_TOL_MEDIUM = 3'd4;
   localparam logic [2:0] REG_TOL_LARGE  = 3'd5;
   localparam logic [2:0] REG_REF_UPPER  = 3'd6;
   localparam logic [2:0] REG_REF_LOWER  = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // One input item
   typedef struct packed {
      logic        kind;
      logic [1:0]  channel;
      logic [15:0] power_meas;
      logic        laser_enabled;
      logic [13:0] pd_average_mv;
   } lpsc_item_type;

   // Per-channel calibration history
   typedef struct packed {
      logic [2:0]  status;
      logic [13:0] ref_mv;
      logic [13:0] prev_ref_mv;
      logic [15:0] prev_power;
      logic [2:0]  stall_count;
   } lpsc_chan_type;

   // Shared thresholds and clamps
   typedef struct packed {
      logic [15:0] tol_small;
      logic [15:0] tol_medium;
      logic [15:0] tol_large;
      logic [13:0] ref_upper_mv;
      logic [13:0] ref_lower_mv;
   } lpsc_cfg_type;

endpackage

/* hdl/lpsc_csr.sv */
// Configuration registers and per-channel target selection.
module lpsc_csr
   import lpsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [1:0]             channel,
   output lpsc_cfg_type           cfg,
   output logic [15:0]            target
);

   logic [15:0]  target_ff [3];
   lpsc_cfg_type cfg_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff[0]        <= 16'd200;
         target_ff[1]        <= 16'd100;
         target_ff[2]        <= 16'd100;
         cfg_ff.tol_small    <= 16'd5;
         cfg_ff.tol_medium   <= 16'd20;
         cfg_ff.tol_large    <= 16'd50;
         cfg_ff.ref_upper_mv <= 14'd3000;
         cfg_ff.ref_lower_mv <= 14'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TARGET_CH0: target_ff[0]        <= csr_wdata;
            REG_TARGET_CH1: target_ff[1]        <= csr_wdata;
            REG_TARGET_CH2: target_ff[2]        <= csr_wdata;
            REG_TOL_SMALL:  cfg_ff.tol_small    <= csr_wdata;
            REG_TOL_MEDIUM: cfg_ff.tol_medium   <= csr_wdata;
            REG_TOL_LARGE:  cfg_ff.tol_large    <= csr_wdata;
            REG_REF_UPPER:  cfg_ff.ref_upper_mv <= csr_wdata[13:0];
            REG_REF_LOWER:  cfg_ff.ref_lower_mv <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   // Channel three has no target register: its target is zero
   always_comb begin
      unique case (channel)
         2'd0:    target = target_ff[0];
         2'd1:    target = target_ff[1];
         2'd2:    target = target_ff[2];
         default: target = 16'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/lpsc_step.sv */
// One calibration step of a channel: next history and reported status.
module lpsc_step
   import lpsc_pkg::*;
#(
   parameter int STEP_LARGE_MV  = 200,
   parameter int STEP_MEDIUM_MV = 50,
   parameter int STEP_SMALL_MV  = 10,
   parameter int PD_MIN_MV      = 50,
   parameter int STALL_LIMIT    = 6
)
(
   input  lpsc_item_type item,
   input  lpsc_chan_type cur,
   input  lpsc_cfg_type  cfg,
   input  logic [15:0]   target,
   output lpsc_chan_type nxt
);

   logic               first_step;
   logic [13:0]        ref_cur;
   logic [13:0]        prev_ref_cur;
   logic               err_pos;
   logic [15:0]        abs_err;
   logic               in_window;
   logic [11:0]        step_mv;
   logic signed [15:0] ref_ext;
   logic signed [15:0] step_ext;
   logic signed [15:0] sum_mv;
   logic signed [15:0] upper_ext;
   logic signed [15:0] lower_ext;
   logic signed [15:0] clamp_hi;
   logic signed [15:0] clamp_lo;
   logic [13:0]        new_ref;
   logic               rising;
   logic [2:0]         stall_inc;
   logic               stalled_out;
   logic               sat;

   // A first step from idle starts from the photodiode reading
   assign first_step   = (cur.status == ST_IDLE);
   assign ref_cur      = first_step ? item.pd_average_mv : cur.ref_mv;
   assign prev_ref_cur = first_step ? item.pd_average_mv : cur.prev_ref_mv;

   // Error magnitude and sign (positive: power below target)
   assign err_pos   = (target > item.power_meas);
   assign abs_err   = err_pos ? (target - item.power_meas) : (item.power_meas - target);
   assign in_window = !err_pos && (abs_err <= cfg.tol_small);

   // Step size by error band
   always_comb begin
      if (abs_err > cfg.tol_large)
         step_mv = 12'(STEP_LARGE_MV);
      else if (abs_err > cfg.tol_medium)
         step_mv = 12'(STEP_MEDIUM_MV);
      else
         step_mv = 12'(STEP_SMALL_MV);
   end

   // Move and clamp: upper first, then lower
   assign ref_ext   = $signed({2'b00, ref_cur});
   assign step_ext  = $signed({4'b0000, step_mv});
   assign sum_mv    = err_pos ? (ref_ext + step_ext) : (ref_ext - step_ext);
   assign upper_ext = $signed({2'b00, cfg.ref_upper_mv});
   assign lower_ext = $signed({2'b00, cfg.ref_lower_mv});
   assign clamp_hi  = (sum_mv > upper_ext) ? upper_ext : sum_mv;
   assign clamp_lo  = (clamp_hi < lower_ext) ? lower_ext : clamp_hi;
   assign new_ref   = clamp_lo[13:0];

   // Stall detection: reference up, power not up
   assign rising      = (new_ref > prev_ref_cur) && (item.power_meas <= cur.prev_power);
   assign stall_inc   = (cur.stall_count < 3'(STALL_LIMIT)) ?
                        (cur.stall_count + 3'd1) : cur.stall_count;
   assign stalled_out = rising && (stall_inc >= 3'(STALL_LIMIT));

   // Clamped with an error beyond the small tolerance
   assign sat = (abs_err > cfg.tol_small) &&
                ((err_pos && (new_ref >= cfg.ref_upper_mv)) ||
                 (!err_pos && (new_ref <= cfg.ref_lower_mv)));

   // Next history
   always_comb begin
      nxt = cur;
      if (item.kind == KIND_CLEAR) begin
         nxt.status      = ST_IDLE;
         nxt.prev_ref_mv = 14'd0;
         nxt.prev_power  = 16'd0;
         nxt.stall_count = 3'd0;
      end else if (!item.laser_enabled) begin
         nxt.status = ST_LASER_OFF;
      end else if ({1'b0, item.pd_average_mv} < 15'(PD_MIN_MV)) begin
         nxt.status = ST_PD_LOW;
      end else begin
         nxt.ref_mv      = ref_cur;
         nxt.prev_ref_mv = prev_ref_cur;
         if (in_window) begin
            nxt.status = ST_DONE;
         end else if (stalled_out) begin
            nxt.status      = ST_NO_RESP;
            nxt.stall_count = stall_inc;
         end else begin
            nxt.stall_count = rising ? stall_inc : 3'd0;
            nxt.ref_mv      = new_ref;
            nxt.prev_ref_mv = new_ref;
            nxt.prev_power  = item.power_meas;
            nxt.status      = sat ? ST_SAT : ST_ADJ;
         end
      end
   end

endmodule

/* hdl/laser_power_step_calibrator.sv */
// Top level of the laser power step calibrator: input stage, channel history, result stage.
//
//  channel  | direction | beat contents
//  ---------+-----------+---------------------------------------------------------
//  req_     | in        | tuser kind; tdata channel, power, laser on, pd average
//  rsp_     | out       | tdata status, reference mV, channel echo
//  csr_     | in        | write enable, register index, write data
//
// One beat per cycle while rsp_ is not stalled; a beat goes via the input, then result register.
// The step is one pass of logic between the input register and the result register,
// reading and writing the channel's history in the same cycle.
// Synchronous reset empties both stages, clears every channel's history and resets the registers.
// A stalled result holds in its register; the input stage still takes one more beat.
module laser_power_step_calibrator
   import lpsc_pkg::*;
#(
   parameter int NUM_CHANNELS   = 3,
   parameter int STEP_LARGE_MV  = 200,
   parameter int STEP_MEDIUM_MV = 50,
   parameter int STEP_SMALL_MV  = 10,
   parameter int PD_MIN_MV      = 50,
   parameter int STALL_LIMIT    = 6
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [39:0]            req_tdata,  // channel, power_meas, laser_enabled, pd_average_mv
   input  logic                   req_tuser,  // kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,  // status, ref_out_mv, channel_out
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic              in_valid_ff, in_valid_in;
   lpsc_item_type     in_item_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [18:0]       rsp_data_ff, rsp_data_in;
   lpsc_chan_type     chan_ff [NUM_CHANNELS];

   logic              req_fire;
   logic              advance;
   logic              chan_valid;
   logic [CH_IDX_W+1:0] chan_wide;
   logic [CH_IDX_W-1:0] chan_idx;
   lpsc_chan_type     cur_chan;
   lpsc_chan_type     nxt_chan;
   lpsc_cfg_type      cfg;
   logic [15:0]       target;

   // Handshake
   assign req_fire   = req_tvalid && req_tready;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Configuration and target select
   lpsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .channel   (in_item_ff.channel),
      .cfg       (cfg),
      .target    (target)
   );

   // Channel lookup
   assign chan_valid = ({2'b00, in_item_ff.channel} < 4'(NUM_CHANNELS));
   assign chan_wide  = {{CH_IDX_W{1'b0}}, in_item_ff.channel};
   assign chan_idx   = chan_wide[CH_IDX_W-1:0];
   assign cur_chan   = chan_valid ? chan_ff[chan_idx] : '0;

   lpsc_step #(
      .STEP_LARGE_MV  (STEP_LARGE_MV),
      .STEP_MEDIUM_MV (STEP_MEDIUM_MV),
      .STEP_SMALL_MV  (STEP_SMALL_MV),
      .PD_MIN_MV      (PD_MIN_MV),
      .STALL_LIMIT    (STALL_LIMIT)
   ) u_step (
      .item   (in_item_ff),
      .cur    (cur_chan),
      .cfg    (cfg),
      .target (target),
      .nxt    (nxt_chan)
   );

   // Next values of the two stages
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (advance)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;

      // Invalid channel: idle, zero reference
      if (chan_valid)
         rsp_data_in = {in_item_ff.channel, nxt_chan.ref_mv, nxt_chan.status};
      else
         rsp_data_in = {in_item_ff.channel, 14'd0, ST_IDLE};
   end

   // Stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.kind          <= req_tuser;
         in_item_ff.channel       <= req_tdata[1:0];
         in_item_ff.power_meas    <= req_tdata[17:2];
         in_item_ff.laser_enabled <= req_tdata[18];
         in_item_ff.pd_average_mv <= req_tdata[32:19];
      end
      if (advance)
         rsp_data_ff <= rsp_data_in;
   end

   // Channel history
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++)
            chan_ff[i] <= '0;
      end else if (advance && chan_valid) begin
         chan_ff[chan_idx] <= nxt_chan;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

   // Input stage only backs up behind a stalled result
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stage blocked without a stalled result");

   // No undefined status code leaves the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= ST_NO_RESP))
      else $error("undefined status code on result");

   // The stall counter written back never passes its limit
   a_stall_bound: assert property (@(posedge clock) disable iff (reset)
      (advance && chan_valid) |-> (nxt_chan.stall_count <= 3'(STALL_LIMIT)))
      else $error("stall counter beyond limit");

   // A no-response result leaves the channel's reference where it stood
   a_no_resp_keeps_ref: assert property (@(posedge clock) disable iff (reset)
      (advance && chan_valid && (nxt_chan.status == ST_NO_RESP) &&
       (cur_chan.status != ST_IDLE)) |-> (nxt_chan.ref_mv == cur_chan.ref_mv))
      else $error("reference moved on no-response");

endmodule
